// ===== hdl/mts_pkg.sv =====
// mts_pkg: shared types and codes for the min tracking stack
// used by the channel interfaces, the stack top level and its checker
// no dependencies

package mts_pkg;

    // action codes on the request channel
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef logic [1:0]         action_t;
    typedef logic signed [15:0] data_t;

    // one stack slot: value and minimum of everything at or below it
    typedef struct packed {
        data_t value;
        data_t minimum;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one response
    typedef struct packed {
        data_t top_value;
        data_t min_value;
        logic  is_empty;
        logic  rejected;
    } result_t;

endpackage

// ===== hdl/mts_req_if.sv =====
// mts_req_if: request channel of the min tracking stack
// depends on mts_pkg

interface mts_req_if;
    logic             valid;
    logic             ready;
    mts_pkg::action_t action;
    mts_pkg::data_t   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== hdl/mts_rsp_if.sv =====
// mts_rsp_if: response channel of the min tracking stack
// depends on mts_pkg

interface mts_rsp_if;
    logic           valid;
    logic           ready;
    mts_pkg::data_t top_value;
    mts_pkg::data_t min_value;
    logic           is_empty;
    logic           rejected;

    modport source (output valid, output top_value, output min_value,
                    output is_empty, output rejected, input ready);
    modport sink   (input valid, input top_value, input min_value,
                    input is_empty, input rejected, output ready);
endinterface

// ===== hdl/mts_ram.sv =====
// mts_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/min_tracking_stack_top.sv =====
// min_tracking_stack_top: bounded stack of signed values with running minimum
// depends on mts_pkg, mts_req_if, mts_rsp_if and mts_ram
//
//   channel  dir  payload                                     transfer when
//   req      in   action, value                               req.valid && req.ready
//   rsp      out  top_value, min_value, is_empty, rejected    rsp.valid && rsp.ready
//
// push, query and a pop that empties or is rejected answer straight from idle; a pop that
// leaves entries answers from the fill state, after the ram read of the new top.
// the top slot is cached in registers, so only a pop needs the memory read port.
// a finished response waits in the output register; the next request is taken
// in the cycle that response transfers.
// reset clears the entry count and control; memory contents need no clearing.

module min_tracking_stack_top #(
    parameter int STACK_DEPTH = 256
) (
    input logic       clk,
    input logic       rst_n,
    mts_req_if.sink   req,
    mts_rsp_if.source rsp
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FILL = 1'b1;

    logic                   state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    mts_pkg::entry_t        top_reg, top_next;
    logic                   out_valid_reg, out_valid_next;
    mts_pkg::result_t       out_reg, out_next;

    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    logic [CW-1:0]          rd_idx;
    mts_pkg::entry_t        wr_entry;
    mts_pkg::entry_t        rd_entry;
    logic [mts_pkg::ENTRY_W-1:0] rd_data;

    // handshake
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rd_idx   = count_reg - CW'(2);
    assign rd_entry = mts_pkg::entry_t'(rd_data);

    // slot storage
    mts_ram #(
        .WIDTH (mts_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    // operation decode and next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_entry.value   = req.value;
        wr_entry.minimum = req.value;

        // new minimum keeps the previous one only when that is strictly smaller
        if ((count_reg != '0) && (top_reg.minimum < req.value))
        begin
            wr_entry.minimum = top_reg.minimum;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // default response: current top, no rejection
                    out_valid_next     = 1'b1;
                    out_next.top_value = top_reg.value;
                    out_next.min_value = top_reg.minimum;
                    out_next.is_empty  = 1'b0;
                    out_next.rejected  = 1'b0;
                    if (count_reg == '0)
                    begin
                        out_next.top_value = '0;
                        out_next.min_value = '0;
                        out_next.is_empty  = 1'b1;
                    end

                    case (req.action)
                        mts_pkg::ACT_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                out_next.rejected = 1'b1;
                            end
                            else
                            begin
                                wr_en              = 1'b1;
                                count_next         = count_reg + CW'(1);
                                top_next           = wr_entry;
                                out_next.top_value = wr_entry.value;
                                out_next.min_value = wr_entry.minimum;
                                out_next.is_empty  = 1'b0;
                            end
                        end
                        mts_pkg::ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.rejected = 1'b1;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                count_next         = '0;
                                out_next.top_value = '0;
                                out_next.min_value = '0;
                                out_next.is_empty  = 1'b1;
                            end
                            else
                            begin
                                // fetch the slot below the top; the fill state answers with it
                                rd_en          = 1'b1;
                                count_next     = count_reg - CW'(1);
                                out_valid_next = 1'b0;
                                state_next     = ST_FILL;
                            end
                        end
                        default:
                        begin
                            // query and the unused code change nothing
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                top_next           = rd_entry;
                out_valid_next     = 1'b1;
                out_next.top_value = rd_entry.value;
                out_next.min_value = rd_entry.minimum;
                out_next.is_empty  = 1'b0;
                out_next.rejected  = 1'b0;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // top slot cache and response payload
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        out_reg <= out_next;
    end

    // response channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.top_value = out_reg.top_value;
    assign rsp.min_value = out_reg.min_value;
    assign rsp.is_empty  = out_reg.is_empty;
    assign rsp.rejected  = out_reg.rejected;

endmodule

// ===== hdl/mts_checker.sv =====
// mts_checker: port level assertions for the min tracking stack
// depends on mts_pkg; bound to min_tracking_stack_top below

module mts_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input mts_pkg::action_t req_action,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input mts_pkg::data_t   rsp_top_value,
    input mts_pkg::data_t   rsp_min_value,
    input logic             rsp_is_empty
);

    // a stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // an empty stack answers zeros
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty |-> (rsp_top_value == '0) && (rsp_min_value == '0))
        else $error("empty response carries nonzero data");

    // the minimum never exceeds the top
    a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_is_empty |-> rsp_min_value <= rsp_top_value)
        else $error("minimum above top value");

    // a push answers in the next cycle with a non-empty stack
    a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == mts_pkg::ACT_PUSH)
        |=> rsp_valid && !rsp_is_empty)
        else $error("push response missing or empty");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_action    (req.action),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_top_value (rsp.top_value),
    .rsp_min_value (rsp.min_value),
    .rsp_is_empty  (rsp.is_empty)
);
